@@ design/thick_polyline_quad_expander_defines.svh @@
// Assertion helpers for the top file, which checks its own logic.
`ifndef THICK_POLYLINE_QUAD_EXPANDER_DEFINES_SVH
`define THICK_POLYLINE_QUAD_EXPANDER_DEFINES_SVH

// The condition must never hold outside of reset.
`define TPQE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the first condition holds, the second holds in the next cycle.
`define TPQE_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) else $error(msg);

`endif

@@ design/tpqe_pkg.sv @@
package tpqe_pkg;

  localparam int COORD_BITS = 16;
  localparam int INDEX_BITS = 16;
  localparam int THICK_BITS = 12;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 32;

  // Q1.14 unit factor.
  localparam logic [14:0] UNIT_FACTOR = 15'd16384;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLOSED_MODE = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_THICKNESS = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_VERTEX = 8'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         final_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] corner0_x;
    logic signed [COORD_BITS-1:0] corner0_y;
    logic signed [COORD_BITS-1:0] corner1_x;
    logic signed [COORD_BITS-1:0] corner1_y;
    logic signed [COORD_BITS-1:0] corner2_x;
    logic signed [COORD_BITS-1:0] corner2_y;
    logic signed [COORD_BITS-1:0] corner3_x;
    logic signed [COORD_BITS-1:0] corner3_y;
    logic [INDEX_BITS-1:0]        base_vertex;
    logic                         last_quad;
  } quad_t;

  // One segment waiting for geometry: start point, end point, index, flag.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic [INDEX_BITS-1:0]        base;
    logic                         last;
  } job_t;

  typedef struct packed {
    logic                  closed_mode;
    logic [THICK_BITS-1:0] line_thickness;
    logic [INDEX_BITS-1:0] start_vertex_index;
  } cfg_t;

endpackage

@@ design/tpqe_front.sv @@
module tpqe_front (
  input  logic            clk,
  input  logic            rst,
  input  tpqe_pkg::cfg_t  cfg,
  input  logic            point_valid,
  output logic            point_stall,
  input  tpqe_pkg::point_t point,
  output logic            push_valid,
  output tpqe_pkg::job_t  push_job,
  input  logic            queue_full
);
  import tpqe_pkg::*;

  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic                         have_point;
  logic [INDEX_BITS-1:0]        next_vertex;
  logic                         pend_valid;
  job_t                         pend_job;
  job_t                         seg_job;
  logic                         accept;
  logic                         closing;

  // A pending closing segment or a full queue holds off the next point.
  assign point_stall = pend_valid || queue_full;
  assign accept = point_valid && !point_stall;
  assign closing = point.final_point && cfg.closed_mode;

  // Segment from the previous point to the new one.
  always_comb begin
    seg_job.ax = prev_x;
    seg_job.ay = prev_y;
    seg_job.bx = point.point_x;
    seg_job.by = point.point_y;
    seg_job.base = next_vertex;
    seg_job.last = point.final_point && !cfg.closed_mode;
  end

  assign push_valid = (accept && have_point) || (pend_valid && !queue_full);
  assign push_job = pend_valid ? pend_job : seg_job;

  // Polyline tracking: first point, previous point and the vertex counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_point <= 1'b0;
      pend_valid <= 1'b0;
      next_vertex <= '0;
      first_x <= '0;
      first_y <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      if (pend_valid && !queue_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        prev_x <= point.point_x;
        prev_y <= point.point_y;
        if (!have_point) begin
          first_x <= point.point_x;
          first_y <= point.point_y;
          next_vertex <= cfg.start_vertex_index;
          have_point <= !point.final_point;
        end else begin
          if (closing) begin
            pend_valid <= 1'b1;
            next_vertex <= next_vertex + INDEX_BITS'(8);
          end else begin
            next_vertex <= next_vertex + INDEX_BITS'(4);
          end
          if (point.final_point) begin
            have_point <= 1'b0;
          end
        end
      end
    end
  end

  // The closing segment runs from the final point back to the first one.
  always_ff @(posedge clk) begin
    if (accept && have_point && closing) begin
      pend_job.ax <= point.point_x;
      pend_job.ay <= point.point_y;
      pend_job.bx <= first_x;
      pend_job.by <= first_y;
      pend_job.base <= next_vertex + INDEX_BITS'(4);
      pend_job.last <= 1'b1;
    end
  end

endmodule

@@ design/tpqe_queue.sv @@
module tpqe_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tpqe_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tpqe_pkg::job_t head_job
);
  import tpqe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10: count <= count + CW'(1);
        2'b01: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ design/tpqe_back.sv @@
module tpqe_back (
  input  logic            clk,
  input  logic            rst,
  input  tpqe_pkg::cfg_t  cfg,
  input  logic            job_valid,
  input  tpqe_pkg::job_t  job,
  output logic            pop,
  output logic            quad_valid,
  input  logic            quad_stall,
  output tpqe_pkg::quad_t quad
);
  import tpqe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_DIV, S_MUL, S_CORN
  } state_t;

  typedef enum logic [1:0] {
    K_HORIZ, K_VERT, K_INCL
  } kind_t;

  state_t state;
  kind_t  kind;

  logic signed [COORD_BITS-1:0] p1x, p1y, p2x, p2y;
  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0]        mx, my;
  logic                         last;
  logic [INDEX_BITS-1:0]        base;

  logic [32:0] sq;
  logic [49:0] rn;
  logic [49:0] root;
  logic [4:0]  sq_step;
  logic [24:0] lenf;
  logic [38:0] dq;
  logic [25:0] rem;
  logic [5:0]  div_step;
  logic        div_sel;
  logic signed [15:0] fc, fs;
  logic signed [28:0] xf, yf;

  // Head-of-queue difference and winding swap.
  logic signed [COORD_BITS:0] hdx, hdy;
  logic                       hswap;
  assign hdx = {job.bx[COORD_BITS-1], job.bx} - {job.ax[COORD_BITS-1], job.ax};
  assign hdy = {job.by[COORD_BITS-1], job.by} - {job.ay[COORD_BITS-1], job.ay};
  assign hswap = (hdx < 0) || (hdy < 0) || ((hdx > 0) && (hdy > 0));

  assign pop = (state == S_IDLE) && job_valid;

  // One squarer, shared by the x and y terms of the squared length.
  logic [31:0] sq_prod;
  assign sq_prod = (state == S_SQX) ? ({16'd0, mx} * {16'd0, mx})
                                    : ({16'd0, my} * {16'd0, my});

  // One square-root step: compare against root plus the current bit.
  logic [49:0] sq_bit;
  logic [49:0] sq_trial;
  assign sq_bit = 50'(1) << {sq_step, 1'b0};
  assign sq_trial = root + sq_bit;

  // One divide step: bring down the next numerator bit.
  logic [26:0] div_r2;
  logic        div_ge;
  assign div_r2 = {rem, dq[38]};
  assign div_ge = (div_r2 >= {2'b00, lenf});

  // Rounded and clamped quotient with the sign of the difference.
  logic [14:0]        q_clamp;
  logic signed [15:0] q_signed;
  logic               q_neg;
  assign q_clamp = (dq > 39'(UNIT_FACTOR)) ? UNIT_FACTOR : dq[14:0];
  assign q_neg = div_sel ? (dy < 0) : (dx < 0);
  assign q_signed = q_neg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});

  // Numerator of a factor: magnitude scaled up plus half the length.
  function automatic logic [38:0] div_num(input logic [COORD_BITS-1:0] mag,
                                          input logic [24:0] len);
    return {1'b0, mag, 22'd0} + {15'd0, len[24:1]};
  endfunction

  // Corner: p scaled to 2^-15, plus offset, rounded half up, saturated.
  function automatic logic signed [COORD_BITS-1:0] corner(
      input logic signed [COORD_BITS-1:0] p, input logic signed [28:0] off);
    logic signed [32:0] w;
    logic signed [17:0] q;
    w = $signed({{2{p[COORD_BITS-1]}}, p, 15'd0}) + 33'(off) + 33'sd16384;
    q = 18'(w >>> 15);
    if (q > 18'sd32767) begin
      return 16'sh7fff;
    end else if (q < -18'sd32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  // Offsets for each corner coordinate, chosen by segment kind.
  logic signed [28:0] h, hf, o0x, o0y, o1x, o1y, o2x, o2y, o3x, o3y;
  always_comb begin
    h = $signed({3'b000, cfg.line_thickness, 14'd0});
    hf = h;
    o0x = -yf; o0y = xf;
    o1x = -yf; o1y = xf;
    o2x = yf;  o2y = -xf;
    o3x = yf;  o3y = -xf;
    unique case (kind)
      K_HORIZ: begin
        hf = (dx > 0) ? h : -h;
        o0x = -hf; o0y = -h;
        o1x = hf;  o1y = -h;
        o2x = hf;  o2y = h;
        o3x = -hf; o3y = h;
      end
      K_VERT: begin
        hf = (dy > 0) ? h : -h;
        o0x = h;  o0y = -hf;
        o1x = h;  o1y = hf;
        o2x = -h; o2y = hf;
        o3x = -h; o3y = -hf;
      end
      K_INCL: begin
        hf = h;
      end
      default: begin
        hf = h;
      end
    endcase
  end

  // Sequencer: squares, square root, two shared divides, scale, corners; axis segments skip to the corners.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      quad_valid <= 1'b0;
      kind <= K_HORIZ;
    end else begin
      // A taken quad leaves the output unless a new one replaces it now.
      if (quad_valid && !quad_stall && (state != S_CORN)) begin
        quad_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            p1x <= hswap ? job.bx : job.ax;
            p1y <= hswap ? job.by : job.ay;
            p2x <= hswap ? job.ax : job.bx;
            p2y <= hswap ? job.ay : job.by;
            dx <= hdx;
            dy <= hdy;
            mx <= COORD_BITS'((hdx < 0) ? -hdx : hdx);
            my <= COORD_BITS'((hdy < 0) ? -hdy : hdy);
            last <= job.last;
            base <= job.base;
            if (hdy == 0) begin
              kind <= K_HORIZ;
              state <= S_CORN;
            end else if (hdx == 0) begin
              kind <= K_VERT;
              state <= S_CORN;
            end else begin
              kind <= K_INCL;
              state <= S_SQX;
            end
          end
        end
        S_SQX: begin
          sq <= {1'b0, sq_prod};
          state <= S_SQY;
        end
        S_SQY: begin
          rn <= {1'b0, sq + {1'b0, sq_prod}, 16'd0};
          root <= '0;
          sq_step <= 5'd24;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (rn >= sq_trial) begin
            rn <= rn - sq_trial;
            root <= (root >> 1) + sq_bit;
          end else begin
            root <= root >> 1;
          end
          if (sq_step == 5'd0) begin
            state <= S_DIV;
            div_sel <= 1'b0;
            div_step <= '0;
            rem <= '0;
            // The root is final once this step lands; load the numerator then.
            if (rn >= sq_trial) begin
              lenf <= (((root >> 1) + sq_bit) == '0) ? 25'd1
                                                      : 25'((root >> 1) + sq_bit);
              dq <= div_num(mx, 25'((root >> 1) + sq_bit));
            end else begin
              lenf <= ((root >> 1) == '0) ? 25'd1 : 25'(root >> 1);
              dq <= div_num(mx, ((root >> 1) == '0) ? 25'd1 : 25'(root >> 1));
            end
          end else begin
            sq_step <= sq_step - 5'd1;
          end
        end
        S_DIV: begin
          if (div_step == 6'd39) begin
            div_step <= '0;
            rem <= '0;
            if (!div_sel) begin
              fc <= q_signed;
              div_sel <= 1'b1;
              dq <= div_num(my, lenf);
            end else begin
              fs <= q_signed;
              state <= S_MUL;
            end
          end else begin
            rem <= div_ge ? 26'(div_r2 - {2'b00, lenf}) : div_r2[25:0];
            dq <= {dq[37:0], div_ge};
            div_step <= div_step + 6'd1;
          end
        end
        S_MUL: begin
          xf <= 29'(fc) * 29'($signed({1'b0, cfg.line_thickness}));
          yf <= 29'(fs) * 29'($signed({1'b0, cfg.line_thickness}));
          state <= S_CORN;
        end
        S_CORN: begin
          if (!quad_valid || !quad_stall) begin
            quad.corner0_x <= corner(p1x, o0x);
            quad.corner0_y <= corner(p1y, o0y);
            quad.corner1_x <= corner(p2x, o1x);
            quad.corner1_y <= corner(p2y, o1y);
            quad.corner2_x <= corner(p2x, o2x);
            quad.corner2_y <= corner(p2y, o2y);
            quad.corner3_x <= corner(p1x, o3x);
            quad.corner3_y <= corner(p1y, o3y);
            quad.base_vertex <= base;
            quad.last_quad <= last;
            quad_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/thick_polyline_quad_expander.sv @@
// Expands a stream of Q12.4 polyline points into one four-corner quad per
// segment, plus the closing segment in closed mode. A front end tracks the
// first and previous point and the vertex counter and queues segment requests;
// a back end computes the corners. Horizontal and vertical segments go straight
// to the corner step of the back end. Inclined segments pass through the
// one-bit-per-cycle square root (25 steps) and the shared restoring divider
// that forms the cosine and then the sine.
// The segment queue holds QUEUE_DEPTH requests, so until it fills, points keep
// arriving while the back end works and while a finished quad waits on the
// output register. The vertex colour register is not stored.
`include "thick_polyline_quad_expander_defines.svh"

module thick_polyline_quad_expander #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tpqe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tpqe_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  point_valid,
  output logic                                  point_stall,
  input  tpqe_pkg::point_t                      point,
  output logic                                  quad_valid,
  input  logic                                  quad_stall,
  output tpqe_pkg::quad_t                       quad
);
  import tpqe_pkg::*;

  cfg_t cfg;
  logic push_valid;
  job_t push_job;
  logic queue_full;
  logic pop;
  logic head_valid;
  job_t head_job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.closed_mode <= 1'b0;
      cfg.line_thickness <= THICK_BITS'(16);
      cfg.start_vertex_index <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOSED_MODE: cfg.closed_mode <= cfg_data[0];
        REG_LINE_THICKNESS: cfg.line_thickness <= cfg_data[THICK_BITS-1:0];
        REG_START_VERTEX: cfg.start_vertex_index <= cfg_data[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  tpqe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point      (point),
    .push_valid (push_valid),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  tpqe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  tpqe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .quad_valid(quad_valid),
    .quad_stall(quad_stall),
    .quad      (quad)
  );

  // A segment request must never be offered to a full queue.
  `TPQE_NEVER(a_no_push_full, push_valid && queue_full, "push into full queue")
  // The back end must never take a request from an empty queue.
  `TPQE_NEVER(a_no_pop_empty, pop && !head_valid, "pop from empty queue")
  // Reset leaves no quad on the output.
  `TPQE_NEXT(a_reset_clears_out, rst, !quad_valid, "quad valid after reset")

endmodule

@@ tb/sv/quad_checker.sv @@
`timescale 1ns / 100ps

module quad_checker
  import tpqe_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      point_valid,
  input  logic                      point_stall,
  input  point_t                    point,
  input  logic                      quad_valid,
  input  logic                      quad_stall,
  input  quad_t                     quad,
  output int                        errors,
  output int                        pending
);

  // Register copies, as the block should hold them.
  logic                  closed_copy;
  logic [THICK_BITS-1:0] thick_copy;
  logic [INDEX_BITS-1:0] start_copy;

  // Polyline state.
  longint                first_x, first_y, prev_x, prev_y;
  logic                  open_line;
  logic [INDEX_BITS-1:0] vertex_count;

  quad_t pending_quads[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bit_w;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= root + bit_w) begin
        n = n - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Offset is in units of 2^-15; round half up to Q12.4 and saturate.
  function automatic logic signed [COORD_BITS-1:0] round_corner(longint p, longint off);
    longint w;
    w = p * 32768 + off + 16384;
    w = w >>> 15;
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    return w[COORD_BITS-1:0];
  endfunction

  // Q1.14 cosine or sine from a magnitude and the length with 8 extra bits.
  function automatic longint unit_factor(longint unsigned mag, bit neg, longint unsigned len8);
    longint unsigned r;
    r = ((mag << 22) + (len8 >> 1)) / len8;
    if (r > 16384) r = 16384;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Corners of the quad for the segment a -> b; advances the vertex counter.
  task automatic expand_segment(input longint ax, input longint ay, input longint bx,
                                input longint by, input logic last);
    longint dx, dy, p1x, p1y, p2x, p2y, t, h, hf, cf, sf, xo, yo;
    longint unsigned mx, my, len8;
    quad_t q;
    bit swap;
    dx = bx - ax;
    dy = by - ay;
    swap = (dx < 0) || (dy < 0) || (dx > 0 && dy > 0);
    p1x = swap ? bx : ax;
    p1y = swap ? by : ay;
    p2x = swap ? ax : bx;
    p2y = swap ? ay : by;
    t = thick_copy;
    h = t * 16384;
    if (dy == 0) begin
      hf = (dx > 0) ? h : -h;
      q.corner0_x = round_corner(p1x, -hf); q.corner0_y = round_corner(p1y, -h);
      q.corner1_x = round_corner(p2x, hf);  q.corner1_y = round_corner(p2y, -h);
      q.corner2_x = round_corner(p2x, hf);  q.corner2_y = round_corner(p2y, h);
      q.corner3_x = round_corner(p1x, -hf); q.corner3_y = round_corner(p1y, h);
    end else if (dx == 0) begin
      hf = (dy > 0) ? h : -h;
      q.corner0_x = round_corner(p1x, h);  q.corner0_y = round_corner(p1y, -hf);
      q.corner1_x = round_corner(p2x, h);  q.corner1_y = round_corner(p2y, hf);
      q.corner2_x = round_corner(p2x, -h); q.corner2_y = round_corner(p2y, hf);
      q.corner3_x = round_corner(p1x, -h); q.corner3_y = round_corner(p1y, -hf);
    end else begin
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      len8 = int_sqrt((mx * mx + my * my) << 16);
      if (len8 == 0) len8 = 1;
      cf = unit_factor(mx, dx < 0, len8);
      sf = unit_factor(my, dy < 0, len8);
      xo = cf * t;
      yo = sf * t;
      q.corner0_x = round_corner(p1x, -yo); q.corner0_y = round_corner(p1y, xo);
      q.corner1_x = round_corner(p2x, -yo); q.corner1_y = round_corner(p2y, xo);
      q.corner2_x = round_corner(p2x, yo);  q.corner2_y = round_corner(p2y, -xo);
      q.corner3_x = round_corner(p1x, yo);  q.corner3_y = round_corner(p1y, -xo);
    end
    q.base_vertex = vertex_count;
    q.last_quad = last;
    vertex_count = vertex_count + INDEX_BITS'(4);
    pending_quads.insert(pending_quads.size(), q);
  endtask

  task automatic report(string field, longint want, longint got);
    $display("%0t: quad field %s is %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) report(field, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      closed_copy = 1'b0;
      thick_copy = 12'd16;
      start_copy = '0;
      first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      open_line = 1'b0;
      vertex_count = '0;
    end else begin
      // Register writes; unknown indexes have no effect.
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOSED_MODE: closed_copy = cfg_data[0];
          REG_LINE_THICKNESS: thick_copy = cfg_data[THICK_BITS-1:0];
          REG_START_VERTEX: start_copy = cfg_data[INDEX_BITS-1:0];
          default: ;
        endcase
      end

      // Compare a delivered quad with the oldest expectation.
      if (quad_valid && !quad_stall) begin
        quad_t want;
        if (pending_quads.size() == 0) begin
          report("unexpected quad", 0, 1);
        end else begin
          want = pending_quads.pop_front();
          compare_field("corner0_x", want.corner0_x, quad.corner0_x);
          compare_field("corner0_y", want.corner0_y, quad.corner0_y);
          compare_field("corner1_x", want.corner1_x, quad.corner1_x);
          compare_field("corner1_y", want.corner1_y, quad.corner1_y);
          compare_field("corner2_x", want.corner2_x, quad.corner2_x);
          compare_field("corner2_y", want.corner2_y, quad.corner2_y);
          compare_field("corner3_x", want.corner3_x, quad.corner3_x);
          compare_field("corner3_y", want.corner3_y, quad.corner3_y);
          compare_field("base_vertex", want.base_vertex, quad.base_vertex);
          compare_field("last_quad", want.last_quad, quad.last_quad);
        end
      end

      // Predict the quads caused by an accepted point.
      if (point_valid && !point_stall) begin
        longint px, py;
        px = point.point_x;
        py = point.point_y;
        if (!open_line) begin
          vertex_count = start_copy;
          first_x = px; first_y = py;
          open_line = !point.final_point;
        end else begin
          expand_segment(prev_x, prev_y, px, py, point.final_point && !closed_copy);
          if (point.final_point && closed_copy)
            expand_segment(px, py, first_x, first_y, 1'b1);
          if (point.final_point) open_line = 1'b0;
        end
        prev_x = px; prev_y = py;
      end
    end
    pending <= pending_quads.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tpqe_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTEX_COLOR = 8'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NOT_PRESENT = 8'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic point_valid = 1'b0;
  logic point_stall;
  point_t point = '0;
  logic quad_valid;
  logic quad_stall = 1'b0;
  quad_t quad;
  int errors, pending;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  logic signed [COORD_BITS-1:0] last_x = '0, last_y = '0;

  always #5 clk = ~clk;

  thick_polyline_quad_expander dut (.*);

  quad_checker checker_i (.*);

  // Watchdog: fails once both the point and the quad channel have gone quiet.
  always @(posedge clk) begin
    if ((point_valid && !point_stall) || (quad_valid && !quad_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: short random stalls, one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        quad_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        quad_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        quad_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        quad_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every quad has come out and the block has gone quiet.
  task automatic drain;
    point_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic setup(logic closed, logic [THICK_BITS-1:0] thick, logic [INDEX_BITS-1:0] start);
    write_reg(REG_CLOSED_MODE, CFG_DATA_BITS'(closed));
    write_reg(REG_LINE_THICKNESS, CFG_DATA_BITS'(thick));
    write_reg(REG_START_VERTEX, CFG_DATA_BITS'(start));
  endtask

  // Offer one point request and hold it until it is taken.
  task automatic send_point(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                            logic fin);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    point_valid <= 1'b1;
    point <= '{point_x: x, point_y: y, final_point: fin};
    @(posedge clk);
    while (point_stall) @(posedge clk);
    last_x = x;
    last_y = y;
  endtask

  // Random point, mostly forming axis, zero-length and inclined segments.
  task automatic send_random_point;
    logic signed [COORD_BITS-1:0] x, y;
    x = COORD_BITS'($urandom);
    y = COORD_BITS'($urandom);
    case ($urandom_range(0, 6))
      0: y = last_y;
      1: x = last_x;
      2: begin x = last_x; y = last_y; end
      3: begin
        x = last_x + $signed(16'($urandom_range(0, 256)) - 16'sd128);
        y = last_y + $signed(16'($urandom_range(0, 256)) - 16'sd128);
      end
      4: begin
        x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      default: ;
    endcase
    send_point(x, y, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    logic [INDEX_BITS-1:0] start_pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: every register, an unknown index, and the special cases.
    write_reg(REG_VERTEX_COLOR, 32'h12345678);
    write_reg(REG_NOT_PRESENT, 32'hffffffff);
    setup(1'b0, 12'd16, 16'd0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd160, 16'sd0, 1'b0);
    send_point(16'sd160, -16'sd80, 1'b0);
    send_point(16'sd160, -16'sd80, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sd37, -16'sd999, 1'b1);
    drain();
    setup(1'b1, 12'd4095, 16'hffff);
    send_point(16'sd100, 16'sd50, 1'b0);
    send_point(-16'sd300, 16'sd200, 1'b1);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    send_point(16'sd5, 16'sd5, 1'b1);
    drain();
    setup(1'b0, 12'd0, 16'd65532);
    send_point(16'sd1, 16'sd2, 1'b0);
    send_point(16'sd3, -16'sd7, 1'b0);
    send_point(16'sd3, 16'sd9, 1'b1);
    drain();

    // Random phases over several register settings.
    for (int phase = 0; phase < 8; phase++) begin
      start_pick = INDEX_BITS'($urandom);
      case (phase)
        0: setup(1'b0, 12'd16, 16'd0);
        1: setup(1'b1, 12'd4095, 16'hfffc);
        2: setup(1'b0, 12'd0, start_pick);
        3: setup(1'b1, 12'd1, start_pick);
        default: setup(1'($urandom_range(0, 1)), THICK_BITS'($urandom), start_pick);
      endcase
      write_reg(REG_VERTEX_COLOR, $urandom);
      if (phase == 1) hold_req = 1'b1;
      if (phase == 7) quiet = 1'b1;
      for (int n = 0; n < 125; n++) begin
        if (phase == 2 && n == 60) begin
          point_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_random_point();
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
